>>> hw/rtl/gha_pkg.sv
// shared constants, codes and control types for the generational handle allocator
// no dependencies; used by gha_ctrl, gha_datapath and generational_handle_allocator
`default_nettype none

package gha_pkg;

    // table geometry
    localparam int ENTRIES   = 1024;
    localparam int WORD_BITS = 16;
    localparam int SLOT_W    = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    // word field widths on the stream ports
    localparam int KIND_W     = 3;
    localparam int SLOT_FLD_W = 11;
    localparam int GEN_FLD_W  = 16;
    localparam int STATUS_W   = 2;
    localparam int TDATA_W    = 32;
    localparam int CMP_W      = (CNT_W > SLOT_FLD_W) ? CNT_W : SLOT_FLD_W;

    typedef logic [WORD_BITS-1:0] word_t;
    localparam word_t MARK_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};

    // request kinds
    localparam logic [KIND_W-1:0] KIND_CREATE      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DESTROY     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOOKUP      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DESTROY_ALL = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LIVE  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OUT_RANGE = 2'd3;

    // datapath operations issued by the controller
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE        = 4'd0;
    localparam logic [OP_W-1:0] OP_POP         = 4'd1;
    localparam logic [OP_W-1:0] OP_READ_POP    = 4'd2;
    localparam logic [OP_W-1:0] OP_READ_IN     = 4'd3;
    localparam logic [OP_W-1:0] OP_READ_WALK   = 4'd4;
    localparam logic [OP_W-1:0] OP_WALK_START  = 4'd5;
    localparam logic [OP_W-1:0] OP_REUSE_DONE  = 4'd6;
    localparam logic [OP_W-1:0] OP_CREATE_NEW  = 4'd7;
    localparam logic [OP_W-1:0] OP_ACCESS_DONE = 4'd8;
    localparam logic [OP_W-1:0] OP_RANGE_DONE  = 4'd9;
    localparam logic [OP_W-1:0] OP_KILL_WALK   = 4'd10;
    localparam logic [OP_W-1:0] OP_ZERO_DONE   = 4'd11;

    typedef struct packed {
        logic            capture;
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic              out_busy;
        logic [KIND_W-1:0] kind;
        logic              free_nonempty;
        logic              in_range;
        logic              walk_done;
    } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/gha_ctrl.sv
// controller state machine for the generational handle allocator
// depends on gha_pkg; drives gha_datapath through cmd_t and reads sts_t
`default_nettype none

module gha_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire gha_pkg::sts_t sts,
    output gha_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE         = 4'd0;
    localparam logic [3:0] ST_DECODE       = 4'd1;
    localparam logic [3:0] ST_POP_WAIT     = 4'd2;
    localparam logic [3:0] ST_CREATE_REUSE = 4'd3;
    localparam logic [3:0] ST_CREATE_NEW   = 4'd4;
    localparam logic [3:0] ST_ACCESS       = 4'd5;
    localparam logic [3:0] ST_RANGE        = 4'd6;
    localparam logic [3:0] ST_WALK_RD      = 4'd7;
    localparam logic [3:0] ST_WALK_WR      = 4'd8;
    localparam logic [3:0] ST_ZERO         = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.op      = gha_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.kind == gha_pkg::KIND_CREATE)
                begin
                    if (sts.free_nonempty)
                    begin
                        cmd.op     = gha_pkg::OP_POP;
                        state_next = ST_POP_WAIT;
                    end
                    else
                    begin
                        state_next = ST_CREATE_NEW;
                    end
                end
                else if (sts.kind inside {gha_pkg::KIND_DESTROY, gha_pkg::KIND_CHECK,
                                          gha_pkg::KIND_LOOKUP})
                begin
                    if (sts.in_range)
                    begin
                        cmd.op     = gha_pkg::OP_READ_IN;
                        state_next = ST_ACCESS;
                    end
                    else
                    begin
                        state_next = ST_RANGE;
                    end
                end
                else if (sts.kind == gha_pkg::KIND_DESTROY_ALL)
                begin
                    cmd.op     = gha_pkg::OP_WALK_START;
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    state_next = ST_ZERO;
                end
            end
            ST_POP_WAIT:
            begin
                cmd.op     = gha_pkg::OP_READ_POP;
                state_next = ST_CREATE_REUSE;
            end
            ST_CREATE_REUSE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = gha_pkg::OP_REUSE_DONE;
                    state_next = ST_IDLE;
                end
            end
            ST_CREATE_NEW:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = gha_pkg::OP_CREATE_NEW;
                    state_next = ST_IDLE;
                end
            end
            ST_ACCESS:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = gha_pkg::OP_ACCESS_DONE;
                    state_next = ST_IDLE;
                end
            end
            ST_RANGE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = gha_pkg::OP_RANGE_DONE;
                    state_next = ST_IDLE;
                end
            end
            ST_WALK_RD:
            begin
                if (sts.walk_done)
                begin
                    state_next = ST_ZERO;
                end
                else
                begin
                    cmd.op     = gha_pkg::OP_READ_WALK;
                    state_next = ST_WALK_WR;
                end
            end
            ST_WALK_WR:
            begin
                cmd.op     = gha_pkg::OP_KILL_WALK;
                state_next = ST_WALK_RD;
            end
            ST_ZERO:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = gha_pkg::OP_ZERO_DONE;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/gha_datapath.sv
// datapath: version table, free stack, counters and result register
// depends on gha_pkg; controlled by gha_ctrl through cmd_t, reports sts_t
`default_nettype none

module gha_datapath (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  [gha_pkg::TDATA_W-1:0]      s_axis_tdata,
    input  wire  [gha_pkg::KIND_W-1:0]       s_axis_tuser,
    input  wire gha_pkg::cmd_t               cmd,
    output gha_pkg::sts_t                    sts,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [gha_pkg::TDATA_W-1:0]      m_axis_tdata,
    output logic [gha_pkg::STATUS_W-1:0]     m_axis_tuser
);

    localparam int SLOT_W     = gha_pkg::SLOT_W;
    localparam int CNT_W      = gha_pkg::CNT_W;
    localparam int CMP_W      = gha_pkg::CMP_W;
    localparam int SLOT_FLD_W = gha_pkg::SLOT_FLD_W;
    localparam int GEN_FLD_W  = gha_pkg::GEN_FLD_W;
    localparam int STATUS_W   = gha_pkg::STATUS_W;
    localparam int PAD_W      = gha_pkg::TDATA_W - 1 - SLOT_FLD_W - GEN_FLD_W;

    // memories
    gha_pkg::word_t vt_mem [gha_pkg::ENTRIES];
    logic [SLOT_W-1:0] fs_mem [gha_pkg::ENTRIES];

    // captured request
    logic [gha_pkg::KIND_W-1:0] kind_reg;
    logic [SLOT_FLD_W-1:0]      slot_reg;
    logic [GEN_FLD_W-1:0]       gen_reg;

    logic [CNT_W-1:0]  free_count_reg, free_count_next;
    logic [CNT_W-1:0]  used_slots_reg, used_slots_next;
    logic [CNT_W-1:0]  walk_reg, walk_next;
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    gha_pkg::word_t    vt_rd_reg;
    logic [SLOT_W-1:0] fs_rd_reg;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg;
    logic                  out_live_reg;
    logic [SLOT_FLD_W-1:0] out_slot_reg;
    logic [GEN_FLD_W-1:0]  out_gen_reg;

    // memory ports
    logic              vt_we, vt_re, fs_we, fs_re;
    logic [SLOT_W-1:0] vt_waddr, vt_raddr, fs_waddr, fs_raddr;
    gha_pkg::word_t    vt_wdata;
    logic [SLOT_W-1:0] fs_wdata;

    // result to load
    logic                  out_load;
    logic [STATUS_W-1:0]   out_status_d;
    logic                  out_live_d;
    logic [SLOT_FLD_W-1:0] out_slot_d;
    logic [GEN_FLD_W-1:0]  out_gen_d;

    gha_pkg::word_t kill_word;
    logic           word_live;
    logic           push_ok;
    logic           used_full;

    assign kill_word = (vt_rd_reg + gha_pkg::word_t'(1)) | gha_pkg::MARK_BIT;
    assign word_live = (vt_rd_reg == gha_pkg::word_t'(gen_reg)) &&
                       !vt_rd_reg[gha_pkg::WORD_BITS-1];
    assign push_ok   = (free_count_reg < CNT_W'(gha_pkg::ENTRIES));
    assign used_full = (used_slots_reg == CNT_W'(gha_pkg::ENTRIES));

    assign sts.out_busy      = out_valid_reg && !m_axis_tready;
    assign sts.kind          = kind_reg;
    assign sts.free_nonempty = (free_count_reg != '0);
    assign sts.in_range      = (CMP_W'(slot_reg) < CMP_W'(used_slots_reg));
    assign sts.walk_done     = (walk_reg >= used_slots_reg);

    always_comb
    begin
        vt_we           = 1'b0;
        vt_waddr        = cur_slot_reg;
        vt_wdata        = kill_word;
        vt_re           = 1'b0;
        vt_raddr        = cur_slot_reg;
        fs_we           = 1'b0;
        fs_waddr        = free_count_reg[SLOT_W-1:0];
        fs_wdata        = cur_slot_reg;
        fs_re           = 1'b0;
        fs_raddr        = SLOT_W'(free_count_reg - CNT_W'(1));
        free_count_next = free_count_reg;
        used_slots_next = used_slots_reg;
        walk_next       = walk_reg;
        cur_slot_next   = cur_slot_reg;
        out_load        = 1'b0;
        out_status_d    = gha_pkg::STATUS_OK;
        out_live_d      = 1'b0;
        out_slot_d      = '0;
        out_gen_d       = '0;
        case (cmd.op)
            gha_pkg::OP_NONE:
            begin
            end
            gha_pkg::OP_POP:
            begin
                fs_re           = 1'b1;
                free_count_next = free_count_reg - CNT_W'(1);
            end
            gha_pkg::OP_READ_POP:
            begin
                vt_re         = 1'b1;
                vt_raddr      = fs_rd_reg;
                cur_slot_next = fs_rd_reg;
            end
            gha_pkg::OP_READ_IN:
            begin
                vt_re         = 1'b1;
                vt_raddr      = SLOT_W'(slot_reg);
                cur_slot_next = SLOT_W'(slot_reg);
            end
            gha_pkg::OP_READ_WALK:
            begin
                vt_re         = 1'b1;
                vt_raddr      = walk_reg[SLOT_W-1:0];
                cur_slot_next = walk_reg[SLOT_W-1:0];
            end
            gha_pkg::OP_WALK_START:
            begin
                walk_next = '0;
            end
            gha_pkg::OP_REUSE_DONE:
            begin
                // reused slot: clear the destroyed mark
                vt_we      = 1'b1;
                vt_wdata   = vt_rd_reg & ~gha_pkg::MARK_BIT;
                out_load   = 1'b1;
                out_live_d = 1'b1;
                out_slot_d = SLOT_FLD_W'(cur_slot_reg);
                out_gen_d  = GEN_FLD_W'(vt_rd_reg & ~gha_pkg::MARK_BIT);
            end
            gha_pkg::OP_CREATE_NEW:
            begin
                out_load = 1'b1;
                if (!used_full)
                begin
                    vt_we           = 1'b1;
                    vt_waddr        = used_slots_reg[SLOT_W-1:0];
                    vt_wdata        = '0;
                    used_slots_next = used_slots_reg + CNT_W'(1);
                    out_live_d      = 1'b1;
                    out_slot_d      = SLOT_FLD_W'(used_slots_reg);
                end
                else
                begin
                    out_status_d = gha_pkg::STATUS_FULL;
                    out_slot_d   = SLOT_FLD_W'(gha_pkg::ENTRIES);
                end
            end
            gha_pkg::OP_ACCESS_DONE:
            begin
                out_load   = 1'b1;
                out_slot_d = SLOT_FLD_W'(cur_slot_reg);
                out_gen_d  = GEN_FLD_W'(vt_rd_reg);
                if (kind_reg == gha_pkg::KIND_DESTROY)
                begin
                    if (word_live)
                    begin
                        vt_we     = 1'b1;
                        out_gen_d = GEN_FLD_W'(kill_word);
                        if (push_ok)
                        begin
                            fs_we           = 1'b1;
                            free_count_next = free_count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        out_status_d = gha_pkg::STATUS_NOT_LIVE;
                    end
                end
                else
                begin
                    out_live_d = word_live;
                end
            end
            gha_pkg::OP_RANGE_DONE:
            begin
                out_load = 1'b1;
                if ((CMP_W'(slot_reg) == CMP_W'(gha_pkg::ENTRIES)) &&
                    (kind_reg != gha_pkg::KIND_LOOKUP))
                begin
                    out_status_d = gha_pkg::STATUS_NOT_LIVE;
                end
                else
                begin
                    out_status_d = gha_pkg::STATUS_OUT_RANGE;
                end
            end
            gha_pkg::OP_KILL_WALK:
            begin
                // destroy-all step: only unmarked slots are freed
                if (!vt_rd_reg[gha_pkg::WORD_BITS-1])
                begin
                    vt_we = 1'b1;
                    if (push_ok)
                    begin
                        fs_we           = 1'b1;
                        free_count_next = free_count_reg + CNT_W'(1);
                    end
                end
                walk_next = walk_reg + CNT_W'(1);
            end
            gha_pkg::OP_ZERO_DONE:
            begin
                out_load = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg <= '0;
            used_slots_reg <= '0;
            walk_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            free_count_reg <= free_count_next;
            used_slots_reg <= used_slots_next;
            walk_reg       <= walk_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cur_slot_reg <= cur_slot_next;
        if (cmd.capture)
        begin
            kind_reg <= s_axis_tuser;
            slot_reg <= s_axis_tdata[SLOT_FLD_W-1:0];
            gen_reg  <= s_axis_tdata[SLOT_FLD_W+GEN_FLD_W-1:SLOT_FLD_W];
        end
        if (out_load)
        begin
            out_status_reg <= out_status_d;
            out_live_reg   <= out_live_d;
            out_slot_reg   <= out_slot_d;
            out_gen_reg    <= out_gen_d;
        end
    end

    // version table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (vt_we)
        begin
            vt_mem[vt_waddr] <= vt_wdata;
        end
        if (vt_re)
        begin
            vt_rd_reg <= vt_mem[vt_raddr];
        end
    end

    // free stack
    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            fs_mem[fs_waddr] <= fs_wdata;
        end
        if (fs_re)
        begin
            fs_rd_reg <= fs_mem[fs_raddr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_gen_reg, out_slot_reg, out_live_reg};

endmodule

`default_nettype wire

>>> hw/rtl/generational_handle_allocator.sv
// generational handle allocator, top level: controller plus datapath
// a create that reuses a freed slot reads the free stack first, then the version table
// a new request word is taken only after the previous one has been handled; destroy all
// reads and then writes the version table for each used slot, as set by the single read
// and write port of the version table
// reset clears the counters and the result valid; the memories are not cleared
`default_nettype none

module generational_handle_allocator (
    input  wire                          clk,
    input  wire                          rst_n,
    // request stream
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [gha_pkg::TDATA_W-1:0]  s_axis_tdata,  // slot[10:0], generation[26:11], zero pad
    input  wire  [gha_pkg::KIND_W-1:0]   s_axis_tuser,  // kind[2:0]
    // result stream
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [gha_pkg::TDATA_W-1:0]  m_axis_tdata,  // live[0], out_slot[11:1],
                                                        // out_generation[27:12], zero pad
    output logic [gha_pkg::STATUS_W-1:0] m_axis_tuser   // status[1:0]
);

    gha_pkg::cmd_t cmd;
    gha_pkg::sts_t sts;

    // sequencing of table reads, writes and the destroy-all walk
    gha_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    // storage, counters and the result register that decouples the output side
    gha_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd           (cmd),
        .sts           (sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
